// ----- rtl/core/pptm_pkg.sv -----
// shared types and constants for the per-cycle peak-to-peak meter
`timescale 1ns / 1ps
`default_nettype none
package pptm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TIME_BITS   = 48;
  localparam int CFG_IDX_BITS = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic signed [SAMPLE_BITS-1:0] THRESHOLD_RESET = '0;
  localparam logic [SAMPLE_BITS-1:0]        MIN_RANGE_RESET = SAMPLE_BITS'(1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_MIN_RANGE = 2'd1
  } cfg_index_e;

  // classified sample handed from front to back
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [TIME_BITS-1:0]          stamp;
    logic                          start;
    logic                          above;
  } item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] peak_to_peak;
    logic [TIME_BITS-1:0]   minimum_time;
    logic [TIME_BITS-1:0]   previous_duration;
    logic                   previous_valid;
    logic [SAMPLE_BITS-1:0] display_range;
    logic [SAMPLE_BITS-1:0] display_midpoint;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/core/pptm_sample_if.sv -----
// sample input channel
`timescale 1ns / 1ps
`default_nettype none
interface pptm_sample_if
  import pptm_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic [TIME_BITS-1:0]          sample_time;
  logic                          record_start;

  modport source (output valid, output sample_value, output sample_time,
                  output record_start, input ready);
  modport sink   (input valid, input sample_value, input sample_time,
                  input record_start, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pptm_result_if.sv -----
// result output channel
`timescale 1ns / 1ps
`default_nettype none
interface pptm_result_if
  import pptm_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] peak_to_peak;
  logic [TIME_BITS-1:0]   minimum_time;
  logic [TIME_BITS-1:0]   previous_duration;
  logic                   previous_valid;
  logic [SAMPLE_BITS-1:0] display_range;
  logic [SAMPLE_BITS-1:0] display_midpoint;

  modport source (output valid, output peak_to_peak, output minimum_time,
                  output previous_duration, output previous_valid,
                  output display_range, output display_midpoint, input ready);
  modport sink   (input valid, input peak_to_peak, input minimum_time,
                  input previous_duration, input previous_valid,
                  input display_range, input display_midpoint, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pptm_cfg_if.sv -----
// configuration write channel
`timescale 1ns / 1ps
`default_nettype none
interface pptm_cfg_if
  import pptm_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] reg_index;
  logic [SAMPLE_BITS-1:0]  reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/per_cycle_peak_to_peak_meter_unit.sv -----
// Per-cycle peak-to-peak meter: takes one timestamped sample per cycle and
// reports, on each rise above the crossing threshold after a complete low phase,
// the peak-to-peak value, the minimum's time, the time since the previous
// measurement and a display range and midpoint. A sample is accepted every
// cycle while the two-entry queue behind the front end has room; the back end
// updates its tracking registers as each sample is taken from the queue; a
// result is written to an output register as its sample is taken and is shown on
// result_o, held until taken. Configuration writes are accepted every cycle
// and should be made only while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none
module per_cycle_peak_to_peak_meter_unit
  import pptm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  pptm_sample_if.sink   sample_i,
  pptm_cfg_if.sink      cfg_i,
  pptm_result_if.source result_o
);

  logic                   push_valid, push_ready;
  item_t                  push_item;
  logic                   pop_valid, pop_ready;
  item_t                  pop_item;
  logic [SAMPLE_BITS-1:0] min_range;

  pptm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (sample_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item),
    .min_range_o  (min_range)
  );

  pptm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  pptm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .min_range_i (min_range),
    .result_o    (result_o)
  );

endmodule
`default_nettype wire

// ----- rtl/core/pptm_front.sv -----
// front end: configuration registers and threshold classification of samples
`timescale 1ns / 1ps
`default_nettype none
module pptm_front
  import pptm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  pptm_sample_if.sink           sample_i,
  pptm_cfg_if.sink              cfg_i,
  output      logic             push_valid_o,
  input  wire logic             push_ready_i,
  output      item_t            push_item_o,
  output      logic [SAMPLE_BITS-1:0] min_range_o
);

  logic signed [SAMPLE_BITS-1:0] threshold_q, threshold_d;
  logic [SAMPLE_BITS-1:0]        min_range_q, min_range_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    threshold_d = threshold_q;
    min_range_d = min_range_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        CFG_THRESHOLD: threshold_d = $signed(cfg_i.reg_data);
        CFG_MIN_RANGE: min_range_d = cfg_i.reg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
      min_range_q <= MIN_RANGE_RESET;
    end else begin
      threshold_q <= threshold_d;
      min_range_q <= min_range_d;
    end
  end

  assign push_valid_o      = sample_i.valid;
  assign sample_i.ready    = push_ready_i;
  assign push_item_o.value = sample_i.sample_value;
  assign push_item_o.stamp = sample_i.sample_time;
  assign push_item_o.start = sample_i.record_start;
  // high phase is strictly above the threshold
  assign push_item_o.above = (sample_i.sample_value > threshold_q);
  assign min_range_o       = min_range_q;

endmodule
`default_nettype wire

// ----- rtl/core/pptm_queue.sv -----
// short queue of classified samples between front and back
`timescale 1ns / 1ps
`default_nettype none
module pptm_queue
  import pptm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output      logic  push_ready_o,
  input  wire item_t push_item_i,
  output      logic  pop_valid_o,
  input  wire logic  pop_ready_i,
  output      item_t pop_item_o
);

  item_t                     slot_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_PTR_BITS:0]   count_q, count_d;
  logic                      push, pop;

  assign push_ready_o = (count_q != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pptm_back.sv -----
// back end: phase tracking, peak and minimum capture, result register
`timescale 1ns / 1ps
`default_nettype none
module pptm_back
  import pptm_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   pop_valid_i,
  output      logic                   pop_ready_o,
  input  wire item_t                  pop_item_i,
  input  wire logic [SAMPLE_BITS-1:0] min_range_i,
  pptm_result_if.source               result_o
);

  logic                          in_low_q, in_low_d;
  logic signed [SAMPLE_BITS-1:0] run_high_q, run_high_d;
  logic signed [SAMPLE_BITS-1:0] held_high_q, held_high_d;
  logic                          peak_valid_q, peak_valid_d;
  logic signed [SAMPLE_BITS-1:0] run_min_q, run_min_d;
  logic [TIME_BITS-1:0]          min_time_q, min_time_d;
  logic                          min_seen_q, min_seen_d;
  logic [TIME_BITS-1:0]          last_time_q, last_time_d;
  logic                          have_result_q, have_result_d;
  logic [SAMPLE_BITS-1:0]        largest_q, largest_d;
  logic [SAMPLE_BITS-1:0]        smallest_q, smallest_d;

  result_t                       res_q, res_d;
  logic                          out_valid_q, out_valid_d;

  logic                          pop;
  logic                          emit;
  logic signed [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS-1:0]        p2p;
  logic [SAMPLE_BITS-1:0]        span;
  logic [SAMPLE_BITS:0]          extreme_sum;

  assign pop_ready_o = !out_valid_q || result_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    in_low_d      = in_low_q;
    run_high_d    = run_high_q;
    held_high_d   = held_high_q;
    peak_valid_d  = peak_valid_q;
    run_min_d     = run_min_q;
    min_time_d    = min_time_q;
    min_seen_d    = min_seen_q;
    last_time_d   = last_time_q;
    have_result_d = have_result_q;
    largest_d     = largest_q;
    smallest_d    = smallest_q;
    res_d         = res_q;
    emit          = 1'b0;
    diff          = '0;
    p2p           = '0;
    span          = '0;
    extreme_sum   = '0;

    if (pop) begin
      if (pop_item_i.start) begin
        in_low_d      = 1'b1;
        run_high_d    = SAMPLE_MIN;
        held_high_d   = '0;
        peak_valid_d  = 1'b0;
        run_min_d     = SAMPLE_MAX;
        min_time_d    = '0;
        min_seen_d    = 1'b0;
        last_time_d   = '0;
        have_result_d = 1'b0;
        largest_d     = '0;
        smallest_d    = '1;
      end
      if (pop_item_i.above) begin
        in_low_d = 1'b0;
        if (min_seen_d && peak_valid_d) begin
          diff = {held_high_d[SAMPLE_BITS-1], held_high_d} -
                 {run_min_d[SAMPLE_BITS-1], run_min_d};
          // peak below minimum saturates to zero
          p2p = (!diff[SAMPLE_BITS] && (diff != '0)) ? diff[SAMPLE_BITS-1:0] : '0;
          if (p2p > largest_d) begin
            largest_d = p2p;
          end
          if (p2p < smallest_d) begin
            smallest_d = p2p;
          end
          span = largest_d - smallest_d;
          if (span < min_range_i) begin
            span = min_range_i;
          end
          extreme_sum             = {1'b0, largest_d} + {1'b0, smallest_d};
          res_d.peak_to_peak      = p2p;
          res_d.minimum_time      = min_time_d;
          res_d.previous_duration = have_result_d ? (min_time_d - last_time_d) : '0;
          res_d.previous_valid    = have_result_d;
          res_d.display_range     = span;
          res_d.display_midpoint  = extreme_sum[SAMPLE_BITS:1];
          last_time_d   = min_time_d;
          have_result_d = 1'b1;
          emit          = 1'b1;
        end
        min_seen_d = 1'b0;
        run_min_d  = SAMPLE_MAX;
        min_time_d = '0;
        if (pop_item_i.value > run_high_d) begin
          run_high_d = pop_item_i.value;
        end
      end else begin
        // falling into the low phase freezes the high peak
        if (!in_low_d) begin
          held_high_d  = run_high_d;
          peak_valid_d = 1'b1;
          run_high_d   = SAMPLE_MIN;
          in_low_d     = 1'b1;
        end
        if (!min_seen_d || (pop_item_i.value < run_min_d)) begin
          run_min_d  = pop_item_i.value;
          min_time_d = pop_item_i.stamp;
          min_seen_d = 1'b1;
        end
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_low_q      <= 1'b1;
      run_high_q    <= SAMPLE_MIN;
      held_high_q   <= '0;
      peak_valid_q  <= 1'b0;
      run_min_q     <= SAMPLE_MAX;
      min_time_q    <= '0;
      min_seen_q    <= 1'b0;
      last_time_q   <= '0;
      have_result_q <= 1'b0;
      largest_q     <= '0;
      smallest_q    <= '1;
      out_valid_q   <= 1'b0;
    end else begin
      in_low_q      <= in_low_d;
      run_high_q    <= run_high_d;
      held_high_q   <= held_high_d;
      peak_valid_q  <= peak_valid_d;
      run_min_q     <= run_min_d;
      min_time_q    <= min_time_d;
      min_seen_q    <= min_seen_d;
      last_time_q   <= last_time_d;
      have_result_q <= have_result_d;
      largest_q     <= largest_d;
      smallest_q    <= smallest_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_o.valid             = out_valid_q;
  assign result_o.peak_to_peak      = res_q.peak_to_peak;
  assign result_o.minimum_time      = res_q.minimum_time;
  assign result_o.previous_duration = res_q.previous_duration;
  assign result_o.previous_valid    = res_q.previous_valid;
  assign result_o.display_range     = res_q.display_range;
  assign result_o.display_midpoint  = res_q.display_midpoint;

  // a result is only produced by a high sample taken from the queue
  a_emit_from_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (pop && pop_item_i.above))
    else $error("result produced without a high sample");

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |-> !emit)
    else $error("pending result overwritten");

  a_have_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (have_result_q && out_valid_q))
    else $error("result history not updated");

  // first result of a record carries no duration
  a_first_duration: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.previous_valid) |-> (res_q.previous_duration == '0))
    else $error("duration without earlier result");

  a_extremes_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_result_q |-> (largest_q >= smallest_q))
    else $error("result extremes out of order");

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// self-checking testbench for the per-cycle peak-to-peak meter unit
`timescale 1ns / 1ps
module tb_top
  import pptm_pkg::*;
;

  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_NOTES    = 40;

  // indexes past the register list, the unit must ignore them
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [TIME_BITS-1:0]          stamp;
    logic                          start;
  } sample_txn_t;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0] index;
    logic [SAMPLE_BITS-1:0]  data;
  } reg_write_t;

  logic clk_i;
  logic rst_ni;

  pptm_sample_if smp_if ();
  pptm_cfg_if    cfg_if ();
  pptm_result_if res_if ();

  per_cycle_peak_to_peak_meter_unit DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp_if),
    .cfg_i    (cfg_if),
    .result_o (res_if)
  );

  sample_txn_t sample_backlog[$];
  reg_write_t  reg_writes[$];
  result_t     expected_readings[$];
  reg_write_t  reg_now;

  int samples_queued, samples_accepted;
  int regs_queued, regs_written;
  int readings_seen, mismatches, settings_run;
  int quiet_cycles;
  bit gaps_off;
  logic [TIME_BITS-1:0] stamp_now;

  // meter model state
  logic signed [SAMPLE_BITS-1:0] thr_reg;
  logic [SAMPLE_BITS-1:0]        min_range_reg;
  bit                            low_phase;
  logic signed [SAMPLE_BITS-1:0] run_peak, held_peak, run_min;
  bit                            peak_held, min_seen, result_seen;
  logic [TIME_BITS-1:0]          min_stamp, last_min_stamp;
  logic [SAMPLE_BITS-1:0]        max_p2p, min_p2p;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void clear_tracking();
    low_phase      = 1'b1;
    run_peak       = SAMPLE_MIN;
    held_peak      = '0;
    peak_held      = 1'b0;
    run_min        = SAMPLE_MAX;
    min_stamp      = '0;
    min_seen       = 1'b0;
    last_min_stamp = '0;
    result_seen    = 1'b0;
    max_p2p        = '0;
    min_p2p        = '1;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_BITS-1:0] idx,
                                         input logic [SAMPLE_BITS-1:0] data);
    case (idx)
      CFG_THRESHOLD: begin
        thr_reg = data;
      end
      CFG_MIN_RANGE: begin
        min_range_reg = data;
      end
      default: begin
      end
    endcase
  endfunction

  // works out the reading, if any, that one sample produces
  function automatic void predict_reading(input sample_txn_t s);
    result_t r;
    int      span;
    if (s.start) clear_tracking();
    if ($signed(s.value) > thr_reg) begin
      low_phase = 1'b0;
      if (min_seen && peak_held) begin
        span = int'(held_peak) - int'(run_min);
        r.peak_to_peak = (span > 0) ? SAMPLE_BITS'(span) : '0;
        if (r.peak_to_peak > max_p2p) max_p2p = r.peak_to_peak;
        if (r.peak_to_peak < min_p2p) min_p2p = r.peak_to_peak;
        r.display_range = max_p2p - min_p2p;
        if (r.display_range < min_range_reg) r.display_range = min_range_reg;
        r.display_midpoint  = SAMPLE_BITS'((int'(max_p2p) + int'(min_p2p)) >> 1);
        r.minimum_time      = min_stamp;
        r.previous_duration = result_seen ? min_stamp - last_min_stamp : '0;
        r.previous_valid    = result_seen;
        last_min_stamp = min_stamp;
        result_seen    = 1'b1;
        expected_readings = {expected_readings, r};
      end
      min_seen  = 1'b0;
      run_min   = SAMPLE_MAX;
      min_stamp = '0;
      if ($signed(s.value) > run_peak) run_peak = s.value;
    end else begin
      if (!low_phase) begin
        held_peak = run_peak;
        peak_held = 1'b1;
        run_peak  = SAMPLE_MIN;
        low_phase = 1'b1;
      end
      if (!min_seen || $signed(s.value) < run_min) begin
        run_min   = s.value;
        min_stamp = s.stamp;
        min_seen  = 1'b1;
      end
    end
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_NOTES) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic check_reading(input result_t got);
    result_t want;
    readings_seen++;
    if (expected_readings.size() == 0) begin
      note_mismatch($sformatf("unexpected reading p2p %0d", got.peak_to_peak));
      return;
    end
    want = expected_readings.pop_front();
    if (got.peak_to_peak !== want.peak_to_peak)
      note_mismatch($sformatf("peak_to_peak got %0d want %0d",
                              got.peak_to_peak, want.peak_to_peak));
    if (got.minimum_time !== want.minimum_time)
      note_mismatch($sformatf("minimum_time got %h want %h",
                              got.minimum_time, want.minimum_time));
    if (got.previous_duration !== want.previous_duration)
      note_mismatch($sformatf("previous_duration got %h want %h",
                              got.previous_duration, want.previous_duration));
    if (got.previous_valid !== want.previous_valid)
      note_mismatch($sformatf("previous_valid got %b want %b",
                              got.previous_valid, want.previous_valid));
    if (got.display_range !== want.display_range)
      note_mismatch($sformatf("display_range got %0d want %0d",
                              got.display_range, want.display_range));
    if (got.display_midpoint !== want.display_midpoint)
      note_mismatch($sformatf("display_midpoint got %0d want %0d",
                              got.display_midpoint, want.display_midpoint));
  endtask

  function automatic bit skip_cycle();
    return !gaps_off && ($urandom_range(99) < 33);
  endfunction

  // sample driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      smp_if.valid <= 1'b0;
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        predict_reading('{smp_if.sample_value, smp_if.sample_time, smp_if.record_start});
        samples_accepted++;
      end
      if (!smp_if.valid || smp_if.ready) begin
        if (sample_backlog.size() > 0 && !skip_cycle()) begin
          smp_if.valid        <= 1'b1;
          smp_if.sample_value <= sample_backlog[0].value;
          smp_if.sample_time  <= sample_backlog[0].stamp;
          smp_if.record_start <= sample_backlog[0].start;
          void'(sample_backlog.pop_front());
        end else begin
          smp_if.valid <= 1'b0;
        end
      end
    end
  end

  // register write driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cfg_if.valid <= 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        apply_register(cfg_if.reg_index, cfg_if.reg_data);
        regs_written++;
      end
      if (!cfg_if.valid || cfg_if.ready) begin
        if (reg_writes.size() > 0 && !skip_cycle()) begin
          reg_now = reg_writes.pop_front();
          cfg_if.valid     <= 1'b1;
          cfg_if.reg_index <= reg_now.index;
          cfg_if.reg_data  <= reg_now.data;
        end else begin
          cfg_if.valid <= 1'b0;
        end
      end
    end
  end

  // reading monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready)
        check_reading('{res_if.peak_to_peak, res_if.minimum_time, res_if.previous_duration,
                        res_if.previous_valid, res_if.display_range,
                        res_if.display_midpoint});
      res_if.ready <= !skip_cycle();
    end
  end

  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic void send(input int value, input logic [TIME_BITS-1:0] stamp,
                               input bit start);
    sample_txn_t s;
    s.value = SAMPLE_BITS'(value);
    s.stamp = stamp;
    s.start = start;
    sample_backlog = {sample_backlog, s};
    samples_queued++;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] level_above(input int thr);
    int top;
    top = int'(SAMPLE_MAX);
    if (thr >= top) return SAMPLE_MAX;
    return SAMPLE_BITS'(thr + 1 + int'($urandom_range(top - thr - 1)));
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] level_below(input int thr);
    int bottom;
    bottom = int'(SAMPLE_MIN);
    return SAMPLE_BITS'(bottom + int'($urandom_range(thr - bottom)));
  endfunction

  // mostly clean high/low cycles around the threshold, some noise in between
  function automatic void queue_waveform(input int count, input int thr);
    int made, hi_len, lo_len, k;
    bit fresh;
    made = 0;
    stamp_now = TIME_BITS'({$urandom, $urandom});
    while (made < count) begin
      if ($urandom_range(99) < 85) begin
        hi_len = $urandom_range(6, 1);
        lo_len = $urandom_range(6, 1);
        fresh  = ($urandom_range(99) < 4);
        for (k = 0; k < hi_len + lo_len; k++) begin
          stamp_now += TIME_BITS'($urandom_range(5000, 1));
          send((k < hi_len) ? int'($signed(level_above(thr))) : int'($signed(level_below(thr))),
               stamp_now, fresh && (k == 0));
          made++;
        end
      end else begin
        send(int'($signed(SAMPLE_BITS'($urandom))), TIME_BITS'({$urandom, $urandom}),
             $urandom_range(3) == 0);
        made++;
      end
    end
  endfunction

  task automatic settle();
    while (samples_accepted != samples_queued || expected_readings.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int data);
    reg_write_t w;
    w.index = idx;
    w.data  = SAMPLE_BITS'(data);
    reg_writes = {reg_writes, w};
    regs_queued++;
    while (regs_written != regs_queued) @(posedge clk_i);
  endtask

  task automatic run_setting(input int thr, input int min_range, input int count);
    settle();
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_MIN_RANGE, min_range);
    queue_waveform(count, thr);
    settings_run++;
  endtask

  initial begin
    int thr;
    rst_ni              = 1'b0;
    gaps_off            = 1'b0;
    smp_if.valid        = 1'b0;
    smp_if.sample_value = '0;
    smp_if.sample_time  = '0;
    smp_if.record_start = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.reg_index    = CFG_THRESHOLD;
    cfg_if.reg_data     = '0;
    res_if.ready        = 1'b0;
    quiet_cycles        = 0;
    thr_reg             = THRESHOLD_RESET;
    min_range_reg       = MIN_RANGE_RESET;
    clear_tracking();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // extreme codes, a sample equal to the threshold, an equal minimum,
    // record restart, time stamps that wrap
    send(SAMPLE_MIN, 48'h0, 1'b1);
    send(SAMPLE_MAX, 48'h1, 1'b0);
    send(SAMPLE_MIN, 48'h2, 1'b0);
    send(1, 48'h3, 1'b0);
    send(0, 48'h4, 1'b0);
    send(-5, 48'h5, 1'b0);
    send(-5, 48'h6, 1'b0);
    send(7, 48'h7, 1'b0);
    send(100, 48'hFFFF_FFFF_FFF0, 1'b1);
    send(-100, 48'hFFFF_FFFF_FFFF, 1'b0);
    send(50, 48'h0, 1'b0);
    send(-200, 48'h10, 1'b0);
    send(60, 48'h11, 1'b0);
    send(-1, 48'hAAAA_5555_AAAA, 1'b0);
    send(2, 48'h5555_AAAA_5555, 1'b0);
    settle();
    // minimum at the most positive code, then the peak falls below it
    write_reg(CFG_THRESHOLD, int'(SAMPLE_MAX));
    write_reg(CFG_MIN_RANGE, 65535);
    send(SAMPLE_MAX, 48'h20, 1'b0);
    settle();
    write_reg(CFG_THRESHOLD, int'(SAMPLE_MIN));
    write_reg(CFG_MIN_RANGE, 0);
    send(-32767, 48'h30, 1'b0);
    send(SAMPLE_MIN, 48'h31, 1'b0);
    send(SAMPLE_MAX, 48'h32, 1'b0);
    settle();
    // writes past the register list leave the settings alone
    write_reg(CFG_SPARE_2, 16'h7FFF);
    write_reg(CFG_SPARE_3, 16'h8000);
    send(SAMPLE_MIN, 48'h40, 1'b0);
    send(5, 48'h41, 1'b0);

    run_setting(0, 1, 250);
    run_setting(int'(SAMPLE_MIN), 0, 150);
    run_setting(int'(SAMPLE_MAX), 65535, 60);
    thr = int'($urandom_range(40000)) - 20000;
    settle();
    gaps_off = 1'b1;
    run_setting(thr, int'($urandom_range(65535)), 250);
    settle();
    gaps_off = 1'b0;
    run_setting(-1000, 40000, 250);
    run_setting(int'($signed(SAMPLE_BITS'($urandom))), int'($urandom_range(65535)), 200);
    run_setting(1234, 65535, 250);
    settle();

    $display("sent %0d samples under %0d random settings plus directed cases",
             samples_accepted, settings_run);
    $display("checked %0d readings, %0d register writes, %0d mismatches",
             readings_seen, regs_written, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pptm_pkg.sv
rtl/core/pptm_sample_if.sv
rtl/core/pptm_result_if.sv
rtl/core/pptm_cfg_if.sv
rtl/core/pptm_front.sv
rtl/core/pptm_queue.sv
rtl/core/pptm_back.sv
rtl/core/per_cycle_peak_to_peak_meter_unit.sv
test/tb_top.sv
